/* design/mlfq_pkg.sv */
// Shared types and constants for the MLFQ process table.
`timescale 1ns / 1ps

package mlfq_pkg;

  localparam logic [2:0] OP_ALLOC    = 3'd0;
  localparam logic [2:0] OP_SET_STAT = 3'd1;
  localparam logic [2:0] OP_FREE     = 3'd2;
  localparam logic [2:0] OP_FREE_ALL = 3'd3;
  localparam logic [2:0] OP_CHARGE   = 3'd4;
  localparam logic [2:0] OP_TICK     = 3'd5;

  localparam logic [2:0] ST_UNUSED  = 3'd0;
  localparam logic [2:0] ST_LOADING = 3'd1;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_PENDING = 3'd5;

  localparam logic [2:0] CFG_LEVEL_COUNT    = 3'd0;
  localparam logic [2:0] CFG_QUANTUM_STEP   = 3'd1;
  localparam logic [2:0] CFG_BOOST_PERIOD   = 3'd2;
  localparam logic [2:0] CFG_SHELL_PID      = 3'd3;
  localparam logic [2:0] CFG_USER_PID_START = 3'd4;

  localparam logic [3:0]  RST_LEVEL_COUNT    = 4'd5;
  localparam logic [7:0]  RST_QUANTUM_STEP   = 8'd5;
  localparam logic [15:0] RST_BOOST_PERIOD   = 16'd500;
  localparam logic [15:0] RST_SHELL_PID      = 16'd2;
  localparam logic [15:0] RST_USER_PID_START = 16'd3;

  localparam logic [3:0] MAX_LEVELS = 4'd8;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] target_pid;
    logic [2:0]  new_status;
    logic [4:0]  slot_index;
    logic [15:0] runtime;
    logic [31:0] tick_count;
    logic        tty_pending;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] given_pid;
    logic [4:0]  given_slot;
    logic [2:0]  level_now;
    logic        boosted;
  } out_word_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [2:0]  status;
    logic [2:0]  level;
    logic [15:0] ticks;
  } slot_t;

  typedef struct packed {
    logic [3:0]  level_count;
    logic [7:0]  quantum_step;
    logic [15:0] boost_period;
    logic [15:0] shell_pid;
    logic [15:0] user_pid_start;
  } cfg_t;

endpackage

/* design/mlfq_process_table.sv */
// Top level of the MLFQ process table: configuration registers, sequencer and output register.
//
// Usage:
//   Input words arrive on in_valid/in_stall/in_word; one result word per input
//   leaves on out_valid/out_stall/out_word. A word moves on a clock edge where
//   valid is high and stall is low.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   One word at a time. Sweeping operations (alloc, set status, free, free
//   all, tick check) visit one slot per cycle through the single update unit
//   and the slot memory, alloc ending early at the first free slot. Charge
//   visits only its one slot; rejected words go straight to the result.
//   in_stall is high from accept until the result is placed in the output
//   register, so the next word is taken while a result still waits there.
// Reset:
//   rst clears all slots (through valid bits, no clearing pass), the pid
//   counter, the boost timestamp and restores register defaults.
// Stall:
//   A stalled result holds in the output register; a finished word then waits
//   in the sequencer and the input side stays stalled.
`timescale 1ns / 1ps

module mlfq_process_table #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mlfq_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mlfq_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  mlfq_pkg::cfg_t      cfg;
  mlfq_pkg::out_word_t res;
  logic                res_load;
  logic                out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_count    <= mlfq_pkg::RST_LEVEL_COUNT;
      cfg.quantum_step   <= mlfq_pkg::RST_QUANTUM_STEP;
      cfg.boost_period   <= mlfq_pkg::RST_BOOST_PERIOD;
      cfg.shell_pid      <= mlfq_pkg::RST_SHELL_PID;
      cfg.user_pid_start <= mlfq_pkg::RST_USER_PID_START;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlfq_pkg::CFG_LEVEL_COUNT:    cfg.level_count    <= cfg_data[3:0];
        mlfq_pkg::CFG_QUANTUM_STEP:   cfg.quantum_step   <= cfg_data[7:0];
        mlfq_pkg::CFG_BOOST_PERIOD:   cfg.boost_period   <= cfg_data;
        mlfq_pkg::CFG_SHELL_PID:      cfg.shell_pid      <= cfg_data;
        mlfq_pkg::CFG_USER_PID_START: cfg.user_pid_start <= cfg_data;
        default: ;
      endcase
    end
  end

  mlfq_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word (in_word),
    .out_free(out_free),
    .res_load(res_load),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word <= res;
    end
  end

endmodule

/* design/mlfq_slot_ram.sv */
// Slot table memory with per-entry valid bits; unwritten entries read as zero.
`timescale 1ns / 1ps

module mlfq_slot_ram #(
  parameter int DEPTH = 17,
  parameter int AW    = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  mlfq_pkg::slot_t wdata,
  input  logic [AW-1:0]  raddr,
  output mlfq_pkg::slot_t rdata
);

  mlfq_pkg::slot_t mem [DEPTH];
  logic [DEPTH-1:0] vld;
  mlfq_pkg::slot_t rdata_q;
  logic            rvld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rvld_q <= vld[raddr];
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule

/* design/mlfq_ctrl.sv */
// Sequencer that sweeps the slot table one entry per cycle through a shared update unit.
`timescale 1ns / 1ps

module mlfq_ctrl #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  mlfq_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  mlfq_pkg::in_word_t  in_word,
  input  logic                out_free,
  output logic                res_load,
  output mlfq_pkg::out_word_t res
);

  localparam int AW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST = AW'(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DONE} state_t;

  state_t          state;
  logic [2:0]      op;
  logic [15:0]     tpid;
  logic [2:0]      nstat;
  logic [15:0]     rt;
  logic            tty;
  logic            do_boost;
  logic [AW-1:0]   idx;
  logic            p_valid;
  logic [AW-1:0]   p_addr;
  logic [15:0]     pid_counter;
  logic [31:0]     last_boost_tick;

  mlfq_pkg::slot_t e;
  mlfq_pkg::slot_t wdata;
  logic            we;
  logic            found;
  logic            finish;
  logic [15:0]     pid_next;
  logic [16:0]     tsum;
  logic [15:0]     tsat;
  logic [11:0]     limit;
  logic [3:0]      lc;
  logic [3:0]      lvl_inc;
  logic            demote;
  logic [31:0]     since_boost;
  logic            accept;

  mlfq_slot_ram #(
    .DEPTH(SLOTS + 1),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (we),
    .waddr(p_addr),
    .wdata(wdata),
    .raddr(idx),
    .rdata(e)
  );

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && (state == S_IDLE);
  assign since_boost = in_word.tick_count - last_boost_tick;
  assign pid_next    = pid_counter + 16'd1;

  always_comb begin
    lc = cfg.level_count;
    if (lc == 4'd0) begin
      lc = 4'd1;
    end else if (lc > mlfq_pkg::MAX_LEVELS) begin
      lc = mlfq_pkg::MAX_LEVELS;
    end
    lvl_inc = {1'b0, e.level} + 4'd1;
    limit   = {8'b0, lvl_inc} * {4'b0, cfg.quantum_step};
    tsum    = {1'b0, e.ticks} + {1'b0, rt};
    tsat    = tsum[16] ? 16'hFFFF : tsum[15:0];
    demote  = (tsat >= {4'b0, limit}) && (lvl_inc < lc);
  end

  always_comb begin
    wdata = e;
    we    = 1'b0;
    found = 1'b0;
    if (state == S_SWEEP && p_valid) begin
      case (op)
        mlfq_pkg::OP_ALLOC: begin
          if (e.status == mlfq_pkg::ST_UNUSED) begin
            wdata = '{pid: pid_next, status: mlfq_pkg::ST_LOADING, level: 3'd0, ticks: 16'd0};
            we    = 1'b1;
            found = 1'b1;
          end
        end
        mlfq_pkg::OP_SET_STAT: begin
          if (e.pid == tpid) begin
            wdata.status = nstat;
            we           = 1'b1;
          end
        end
        mlfq_pkg::OP_FREE: begin
          if (e.pid == tpid) begin
            wdata.status = mlfq_pkg::ST_UNUSED;
            we           = 1'b1;
          end
        end
        mlfq_pkg::OP_FREE_ALL: begin
          if (e.pid >= cfg.user_pid_start && e.status != mlfq_pkg::ST_UNUSED) begin
            wdata.status = mlfq_pkg::ST_UNUSED;
            we           = 1'b1;
          end
        end
        mlfq_pkg::OP_CHARGE: begin
          we = 1'b1;
          if (demote) begin
            wdata.level = lvl_inc[2:0];
            wdata.ticks = 16'd0;
          end else begin
            wdata.ticks = tsat;
          end
        end
        mlfq_pkg::OP_TICK: begin
          if (e.status != mlfq_pkg::ST_UNUSED &&
              (do_boost || (tty && e.pid == cfg.shell_pid))) begin
            wdata.level = 3'd0;
            wdata.ticks = 16'd0;
            we          = 1'b1;
          end
        end
        default: ;
      endcase
    end
    finish = p_valid && (op == mlfq_pkg::OP_CHARGE || p_addr == LAST || found);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      res_load        <= 1'b0;
      p_valid         <= 1'b0;
      pid_counter     <= '0;
      last_boost_tick <= '0;
    end else begin
      res_load <= 1'b0;
      unique case (state)
        S_IDLE: begin
          p_valid <= 1'b0;
          if (accept) begin
            op       <= in_word.opcode;
            tpid     <= in_word.target_pid;
            nstat    <= in_word.new_status;
            rt       <= in_word.runtime;
            tty      <= in_word.tty_pending;
            do_boost <= 1'b0;
            res      <= '0;
            idx      <= '0;
            state    <= S_SWEEP;
            case (in_word.opcode)
              mlfq_pkg::OP_ALLOC: begin
                idx <= AW'(1);
              end
              mlfq_pkg::OP_SET_STAT: begin
                if (in_word.new_status >= mlfq_pkg::ST_READY &&
                    in_word.new_status <= mlfq_pkg::ST_PENDING) begin
                  res.ok <= 1'b1;
                end else begin
                  state <= S_DONE;
                end
              end
              mlfq_pkg::OP_FREE, mlfq_pkg::OP_FREE_ALL: begin
                res.ok <= 1'b1;
              end
              mlfq_pkg::OP_CHARGE: begin
                if (32'(in_word.slot_index) <= 32'(SLOTS)) begin
                  idx    <= AW'(in_word.slot_index);
                  res.ok <= 1'b1;
                end else begin
                  state <= S_DONE;
                end
              end
              mlfq_pkg::OP_TICK: begin
                res.ok <= 1'b1;
                if (since_boost >= {16'b0, cfg.boost_period}) begin
                  do_boost        <= 1'b1;
                  res.boosted     <= 1'b1;
                  last_boost_tick <= in_word.tick_count;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SWEEP: begin
          p_valid <= 1'b1;
          p_addr  <= idx;
          if (idx != LAST) begin
            idx <= idx + AW'(1);
          end
          if (found) begin
            pid_counter    <= pid_next;
            res.ok         <= 1'b1;
            res.given_pid  <= pid_next;
            res.given_slot <= 5'(p_addr);
          end
          if (op == mlfq_pkg::OP_CHARGE && p_valid) begin
            res.level_now <= wdata.level;
          end
          if (finish) begin
            p_valid <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_load <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the MLFQ process table: shadow table model, random traffic.
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS = 16;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_WORDS = 137;
  // ~1400 words, each at most a full sweep plus sender gap and receiver stall
  localparam int RUN_LIMIT = 600000;
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;
  localparam logic [2:0] ST_BAD_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mlfq_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mlfq_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = mlfq_pkg::CFG_LEVEL_COUNT;
  logic [15:0] cfg_data = '0;

  mlfq_process_table #(.SLOTS(SLOTS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow process table and registers
  logic [15:0] tbl_pid[0:SLOTS];
  logic [2:0] tbl_status[0:SLOTS];
  logic [2:0] tbl_level[0:SLOTS];
  logic [15:0] tbl_ticks[0:SLOTS];
  logic [15:0] pid_seq;
  logic [31:0] boost_stamp;
  logic [3:0] c_levels;
  logic [7:0] c_quantum;
  logic [15:0] c_period;
  logic [15:0] c_shell;
  logic [15:0] c_user_start;

  mlfq_pkg::in_word_t op_q[$];
  mlfq_pkg::out_word_t outcome_q[$];
  int words_issued = 0;
  int words_checked = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  logic [15:0] gen_pid;
  logic [31:0] gen_tick = '0;

  function automatic mlfq_pkg::out_word_t run_table_op(input mlfq_pkg::in_word_t w);
    mlfq_pkg::out_word_t r;
    int i;
    int s;
    bit found;
    int unsigned lc, sum, cur, lim;
    logic [31:0] since;
    r = '0;
    found = 1'b0;
    case (w.opcode)
      mlfq_pkg::OP_ALLOC: begin
        for (i = 1; i <= SLOTS; i++) begin
          if (!found && tbl_status[i] == mlfq_pkg::ST_UNUSED) begin
            found = 1'b1;
            pid_seq = pid_seq + 16'd1;
            tbl_pid[i] = pid_seq;
            tbl_status[i] = mlfq_pkg::ST_LOADING;
            tbl_level[i] = '0;
            tbl_ticks[i] = '0;
            r.ok = 1'b1;
            r.given_pid = pid_seq;
            r.given_slot = i[4:0];
          end
        end
      end
      mlfq_pkg::OP_SET_STAT: begin
        if (w.new_status >= mlfq_pkg::ST_READY && w.new_status <= mlfq_pkg::ST_PENDING) begin
          for (i = 0; i <= SLOTS; i++)
            if (tbl_pid[i] == w.target_pid) tbl_status[i] = w.new_status;
          r.ok = 1'b1;
        end
      end
      mlfq_pkg::OP_FREE: begin
        for (i = 0; i <= SLOTS; i++)
          if (tbl_pid[i] == w.target_pid) tbl_status[i] = mlfq_pkg::ST_UNUSED;
        r.ok = 1'b1;
      end
      mlfq_pkg::OP_FREE_ALL: begin
        for (i = 0; i <= SLOTS; i++)
          if (tbl_pid[i] >= c_user_start && tbl_status[i] != mlfq_pkg::ST_UNUSED)
            tbl_status[i] = mlfq_pkg::ST_UNUSED;
        r.ok = 1'b1;
      end
      mlfq_pkg::OP_CHARGE: begin
        s = int'(w.slot_index);
        if (s <= SLOTS) begin
          lc = 32'(c_levels);
          if (lc < 1) lc = 1;
          if (lc > 32'(mlfq_pkg::MAX_LEVELS)) lc = 32'(mlfq_pkg::MAX_LEVELS);
          sum = 32'(tbl_ticks[s]) + 32'(w.runtime);
          if (sum > 32'hFFFF) sum = 32'hFFFF;
          cur = 32'(tbl_level[s]);
          lim = (cur + 1) * 32'(c_quantum);
          tbl_ticks[s] = sum[15:0];
          if (sum >= lim && cur + 1 < lc) begin
            tbl_level[s] = tbl_level[s] + 3'd1;
            tbl_ticks[s] = '0;
          end
          r.level_now = tbl_level[s];
          r.ok = 1'b1;
        end
      end
      mlfq_pkg::OP_TICK: begin
        if (w.tty_pending) begin
          for (i = 0; i <= SLOTS; i++)
            if (tbl_pid[i] == c_shell && tbl_status[i] != mlfq_pkg::ST_UNUSED) begin
              tbl_level[i] = '0;
              tbl_ticks[i] = '0;
            end
        end
        since = w.tick_count - boost_stamp;
        if (since >= {16'd0, c_period}) begin
          for (i = 0; i <= SLOTS; i++)
            if (tbl_status[i] != mlfq_pkg::ST_UNUSED) begin
              tbl_level[i] = '0;
              tbl_ticks[i] = '0;
            end
          boost_stamp = w.tick_count;
          r.boosted = 1'b1;
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string msg);
    if (fail_cnt < 100) $display("mismatch: %s", msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report($sformatf("word %0d %s got %0h want %0h", words_checked, name, got, want));
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
  end

  // sender: bursts of words with random gaps
  always @(posedge clk) begin : drive
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) outcome_q.push_back(run_table_op(in_word));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_q.size() > 0) begin
          in_word <= op_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between random modes
  always @(posedge clk) begin : watch
    mlfq_pkg::out_word_t want;
    logic hold;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(32, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: hold = 1'b0;
        1: hold = ($urandom_range(0, 3) == 0);
        2: hold = ($urandom_range(0, 9) < 7);
        default: hold = ((cycle_cnt % 5) < 2);
      endcase
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report("result word with nothing outstanding");
        end else begin
          want = outcome_q.pop_front();
          check_field("ok", 16'(out_word.ok), 16'(want.ok));
          check_field("given_pid", out_word.given_pid, want.given_pid);
          check_field("given_slot", 16'(out_word.given_slot), 16'(want.given_slot));
          check_field("level_now", 16'(out_word.level_now), 16'(want.level_now));
          check_field("boosted", 16'(out_word.boosted), 16'(want.boosted));
          words_checked++;
        end
      end
      out_stall <= hold;
    end
  end

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("[mlfq_process_table] ERROR");
    $finish;
  end

  task automatic queue_word(input mlfq_pkg::in_word_t w);
    op_q.push_back(w);
    words_issued++;
  endtask

  function automatic mlfq_pkg::in_word_t dir_word(input logic [2:0] op, input logic [15:0] pid,
                                                  input logic [2:0] stat, input logic [4:0] slot,
                                                  input logic [15:0] rt,
                                                  input logic [31:0] tick, input logic tty);
    mlfq_pkg::in_word_t w;
    w.opcode = op;
    w.target_pid = pid;
    w.new_status = stat;
    w.slot_index = slot;
    w.runtime = rt;
    w.tick_count = tick;
    w.tty_pending = tty;
    return w;
  endfunction

  function automatic logic [15:0] pick_pid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return c_shell;
    if (r < 20) return 16'($urandom);
    return 16'($urandom_range((gen_pid > 24) ? gen_pid - 24 : 0, gen_pid));
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return mlfq_pkg::OP_ALLOC;
    if (r < 35) return mlfq_pkg::OP_SET_STAT;
    if (r < 46) return mlfq_pkg::OP_FREE;
    if (r < 49) return mlfq_pkg::OP_FREE_ALL;
    if (r < 78) return mlfq_pkg::OP_CHARGE;
    if (r < 96) return mlfq_pkg::OP_TICK;
    if (r < 98) return OP_BAD_LO;
    return OP_BAD_HI;
  endfunction

  function automatic mlfq_pkg::in_word_t gen_word(input logic [2:0] op);
    mlfq_pkg::in_word_t w;
    int r;
    w.opcode = op;
    w.target_pid = 16'($urandom);
    w.new_status = 3'($urandom);
    w.slot_index = 5'($urandom);
    w.runtime = 16'($urandom);
    w.tick_count = $urandom;
    w.tty_pending = 1'($urandom);
    r = $urandom_range(0, 99);
    case (op)
      mlfq_pkg::OP_ALLOC: gen_pid = gen_pid + 16'd1;
      mlfq_pkg::OP_SET_STAT, mlfq_pkg::OP_FREE: begin
        if (r < 85) w.target_pid = pick_pid();
        if (op == mlfq_pkg::OP_SET_STAT && $urandom_range(0, 9) < 8)
          w.new_status = 3'($urandom_range(mlfq_pkg::ST_READY, mlfq_pkg::ST_PENDING));
      end
      mlfq_pkg::OP_CHARGE: begin
        if (r < 80) w.slot_index = 5'($urandom_range(1, SLOTS));
        else if (r < 85) w.slot_index = '0;
        else if (r < 92) w.slot_index = 5'($urandom_range(SLOTS + 1, 31));
        r = $urandom_range(0, 99);
        if (r < 70) w.runtime = 16'($urandom_range(0, c_quantum * 3 + 2));
        else if (r < 90) w.runtime = 16'($urandom_range(0, 2000));
      end
      mlfq_pkg::OP_TICK: begin
        if (r < 85) gen_tick = gen_tick + $urandom_range(0, c_period / 4 + 8);
        else if (r < 95) gen_tick = $urandom;
        else gen_tick = gen_tick - $urandom_range(1, 50);
        w.tick_count = gen_tick;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_drained();
    while (words_checked < words_issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mlfq_pkg::CFG_LEVEL_COUNT: c_levels = val[3:0];
      mlfq_pkg::CFG_QUANTUM_STEP: c_quantum = val[7:0];
      mlfq_pkg::CFG_BOOST_PERIOD: c_period = val;
      mlfq_pkg::CFG_SHELL_PID: c_shell = val;
      mlfq_pkg::CFG_USER_PID_START: c_user_start = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [3:0] lc, input logic [7:0] q, input logic [15:0] bp,
                            input logic [15:0] sh, input logic [15:0] ups);
    write_reg(mlfq_pkg::CFG_LEVEL_COUNT, {12'd0, lc});
    write_reg(mlfq_pkg::CFG_QUANTUM_STEP, {8'd0, q});
    write_reg(mlfq_pkg::CFG_BOOST_PERIOD, bp);
    write_reg(mlfq_pkg::CFG_SHELL_PID, sh);
    write_reg(mlfq_pkg::CFG_USER_PID_START, ups);
  endtask

  initial begin : main
    int ph;
    int n;
    int k;
    for (k = 0; k <= SLOTS; k++) begin
      tbl_pid[k] = '0;
      tbl_status[k] = mlfq_pkg::ST_UNUSED;
      tbl_level[k] = '0;
      tbl_ticks[k] = '0;
    end
    pid_seq = '0;
    boost_stamp = '0;
    c_levels = mlfq_pkg::RST_LEVEL_COUNT;
    c_quantum = mlfq_pkg::RST_QUANTUM_STEP;
    c_period = mlfq_pkg::RST_BOOST_PERIOD;
    c_shell = mlfq_pkg::RST_SHELL_PID;
    c_user_start = mlfq_pkg::RST_USER_PID_START;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed words under reset defaults
    repeat (3) queue_word(dir_word(mlfq_pkg::OP_ALLOC, '0, '0, '0, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_SET_STAT, 16'd1, mlfq_pkg::ST_PENDING, '0, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_SET_STAT, 16'd2, mlfq_pkg::ST_READY, '0, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_SET_STAT, 16'd3, mlfq_pkg::ST_UNUSED, '0, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_SET_STAT, 16'd3, ST_BAD_HI, '0, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_CHARGE, '0, '0, 5'd1, {8'd0, mlfq_pkg::RST_QUANTUM_STEP},
                        '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_CHARGE, '0, '0, 5'd1, 16'hFFFF, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_CHARGE, '0, '0, 5'd2, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_CHARGE, '0, '0, 5'd0, 16'd7, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_CHARGE, '0, '0, 5'(SLOTS + 1), 16'd9, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_CHARGE, '0, '0, 5'h1F, 16'd9, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_TICK, '0, '0, '0, '0, 32'd10, 1'b1));
    queue_word(dir_word(mlfq_pkg::OP_TICK, '0, '0, '0, '0, 32'd600, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_TICK, '0, '0, '0, '0, 32'hFFFF_FFFF, 1'b1));
    queue_word(dir_word(mlfq_pkg::OP_TICK, '0, '0, '0, '0, 32'd0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_FREE, 16'd2, '0, '0, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_FREE, 16'd0, '0, '0, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_SET_STAT, 16'hFFFF, mlfq_pkg::ST_READY, '0, '0, '0, 1'b0));
    queue_word(dir_word(mlfq_pkg::OP_FREE_ALL, '0, '0, '0, '0, '0, 1'b0));
    queue_word(dir_word(OP_BAD_LO, 16'd1, mlfq_pkg::ST_READY, 5'd1, 16'd1, '0, 1'b1));
    queue_word(dir_word(OP_BAD_HI, 16'd1, mlfq_pkg::ST_READY, 5'd1, 16'd1, '0, 1'b1));
    repeat (2) queue_word(dir_word(mlfq_pkg::OP_ALLOC, '0, '0, '0, '0, '0, 1'b0));

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: set_config(4'd1, 8'd1, 16'd1, 16'd0, 16'd0);
        1: set_config(4'd8, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_config(4'd0, 8'd0, 16'd0, pid_seq + 16'd2, pid_seq);
        3: set_config(4'hF, 8'($urandom_range(1, 10)), 16'($urandom_range(1, 300)),
                      pid_seq + 16'd1, 16'($urandom_range(0, pid_seq + 5)));
        NUM_PHASES - 1: set_config(mlfq_pkg::RST_LEVEL_COUNT, mlfq_pkg::RST_QUANTUM_STEP,
                                   mlfq_pkg::RST_BOOST_PERIOD, mlfq_pkg::RST_SHELL_PID,
                                   mlfq_pkg::RST_USER_PID_START);
        default: set_config(4'($urandom_range(0, 15)),
                            ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(1, 12)),
                            16'($urandom_range(0, 2000)),
                            pid_seq + 16'($urandom_range(0, 10)),
                            16'($urandom_range(0, pid_seq + 20)));
      endcase
      gen_pid = pid_seq;
      n = 0;
      while (n < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 4) begin
          // run the table into the full condition
          repeat (SLOTS + 1) queue_word(gen_word(mlfq_pkg::OP_ALLOC));
          n += SLOTS + 1;
        end else begin
          queue_word(gen_word(pick_op()));
          n++;
        end
      end
    end

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    if (outcome_q.size() != 0)
      report($sformatf("%0d result words never arrived", outcome_q.size()));
    if (fail_cnt == 0) begin
      $display("[mlfq_process_table] OK");
    end else begin
      $display("[mlfq_process_table] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/mlfq_pkg.sv
design/mlfq_slot_ram.sv
design/mlfq_ctrl.sv
design/mlfq_process_table.sv
tb/sv/testbench.sv
